>>> rtl/tics_pkg.sv
// Shared widths and command codes for the tabulated inverse-CDF sampler.
package tics_pkg;

  localparam int DATA_W = 32;  // CDF, uniform and energy words
  localparam int IDX_W  = 8;   // entry index field
  localparam int CNT_W  = 9;   // entry count register

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef logic [DATA_W-1:0] word_t;

endpackage

>>> rtl/tics_div.sv
// Restoring divider, one quotient bit per cycle; quotient must fit in one word.
module tics_div
  import tics_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [2*DATA_W-1:0] dividend_i,
  input  word_t               divisor_i,
  output logic                done_o,
  output word_t               quot_o
);

  localparam int SW = $clog2(DATA_W);

  word_t          rem_q;
  word_t          quo_q;
  word_t          div_q;
  logic [SW-1:0]  cnt_q;
  logic           busy_q;
  logic           done_q;
  logic [DATA_W+1:0] trial;
  logic           fits;

  // remainder stays below divisor, so the shifted value fits in DATA_W+1 bits
  assign trial = {1'b0, rem_q, quo_q[DATA_W-1]} - {2'b00, div_q};
  assign fits  = ~trial[DATA_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + SW'(1);
        if (cnt_q == SW'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[2*DATA_W-1:DATA_W];
      quo_q <= dividend_i[DATA_W-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[DATA_W-1:0] : {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
      quo_q <= {quo_q[DATA_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/tabulated_inverse_cdf_sampler_top.sv
// Top level of the tabulated inverse-CDF sampler: table memories, scan FSM, output register.
//
// Input channel (in_valid_i / in_stall_o): a transaction with cmd_i = load writes
// cdf_value_i and energy_value_i at entry_index_i (indexes past the table are
// dropped) and produces no result. A transaction with
// cmd_i = sample draws one energy for uniform_value_i.
// Output channel (out_valid_o / out_stall_i): one transaction per sample,
// energy_sample_o plus in_range_o (0 when the uniform value saturated to the
// first or last table energy).
// cfg_we_i writes entry_count (points in use, clamped to 2..TABLE_DEPTH); the user
// must write it only while idle, which the block itself does not enforce. A sample
// reads the last point, then scans the table from entry 0 one entry per cycle
// through the single read port of each memory; the bin found at entry i is
// interpolated with a 32x32 multiply and a bit-serial divide.
// One sample is in flight at a time; loads are accepted every cycle while idle.
// A finished result waits in the output register while the receiver stalls; the
// block keeps taking loads meanwhile and holds a new sample result until it drains.
// Reset clears control state and sets entry_count to 2; table contents are
// undefined until loaded.
module tabulated_inverse_cdf_sampler_top
  import tics_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  word_t             cdf_value_i,
  input  word_t             energy_value_i,
  input  word_t             uniform_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output word_t             energy_sample_o,
  output logic              in_range_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (CW > CNT_W) ? CW : CNT_W;
  localparam int IW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_REQ_LAST, S_CHK_LAST, S_SCAN, S_MUL, S_DIV_START, S_DIV_WAIT, S_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] entry_count_q;

  word_t            cdf_mem    [TABLE_DEPTH];
  word_t            energy_mem [TABLE_DEPTH];
  word_t            rd_cdf_q;
  word_t            rd_energy_q;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  logic             in_accept;
  logic [EW-1:0]    n_clamped;
  logic [AW-1:0]    last_idx_q;
  logic [AW-1:0]    idx_q;
  word_t            u_q;
  logic             hi_sat_q;
  word_t            last_e_q;
  word_t            prev_c_q;
  word_t            prev_e_q;
  logic             prev_le_q;

  word_t            num_q;
  word_t            den_q;
  word_t            span_q;
  logic             sub_q;
  word_t            e0_q;
  logic [2*DATA_W-1:0] prod_q;
  logic             div_start;
  logic             div_done;
  word_t            div_quot;

  word_t            res_q;
  logic             res_hit_q;
  logic             out_valid_q;
  word_t            out_energy_q;
  logic             out_hit_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    n_clamped = EW'(entry_count_q);
    if (n_clamped > EW'(TABLE_DEPTH)) n_clamped = EW'(TABLE_DEPTH);
    if (n_clamped < EW'(2))           n_clamped = EW'(2);
  end

  assign wr_en   = in_accept && (cmd_i == CMD_LOAD) &&
                   (IW'(entry_index_i) < IW'(TABLE_DEPTH));
  assign wr_addr = AW'(entry_index_i);

  always_comb begin
    case (state_q)
      S_REQ_LAST: rd_addr = last_idx_q;
      S_SCAN:     rd_addr = idx_q + AW'(1);
      default:    rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cdf_mem[wr_addr]    <= cdf_value_i;
      energy_mem[wr_addr] <= energy_value_i;
    end
    rd_cdf_q    <= cdf_mem[rd_addr];
    rd_energy_q <= energy_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= CNT_W'(2);
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  assign div_start = (state_q == S_DIV_START);

  tics_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // S_DONE refills the output register itself
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_accept && (cmd_i == CMD_SAMPLE)) begin
            u_q        <= uniform_value_i;
            last_idx_q <= AW'(n_clamped - EW'(1));
            state_q    <= S_REQ_LAST;
          end
        end
        S_REQ_LAST: state_q <= S_CHK_LAST;
        S_CHK_LAST: begin
          hi_sat_q <= (u_q >= rd_cdf_q);
          last_e_q <= rd_energy_q;
          idx_q    <= '0;
          state_q  <= S_SCAN;
        end
        S_SCAN: begin
          idx_q     <= idx_q + AW'(1);
          prev_c_q  <= rd_cdf_q;
          prev_e_q  <= rd_energy_q;
          prev_le_q <= (rd_cdf_q <= u_q);
          if (idx_q == '0) begin
            // below the first point wins over above the last
            if (u_q < rd_cdf_q) begin
              res_q     <= rd_energy_q;
              res_hit_q <= 1'b0;
              state_q   <= S_DONE;
            end else if (hi_sat_q) begin
              res_q     <= last_e_q;
              res_hit_q <= 1'b0;
              state_q   <= S_DONE;
            end
          end else if (prev_le_q && (u_q < rd_cdf_q)) begin
            num_q   <= u_q - prev_c_q;
            den_q   <= rd_cdf_q - prev_c_q;
            sub_q   <= (rd_energy_q < prev_e_q);
            span_q  <= (rd_energy_q < prev_e_q) ? prev_e_q - rd_energy_q
                                                : rd_energy_q - prev_e_q;
            e0_q    <= prev_e_q;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= num_q * span_q;
          state_q <= S_DIV_START;
        end
        S_DIV_START: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            res_q     <= sub_q ? e0_q - div_quot : e0_q + div_quot;
            res_hit_q <= 1'b1;
            state_q   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_energy_q <= res_q;
            out_hit_q    <= res_hit_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign energy_sample_o = out_energy_q;
  assign in_range_o      = out_hit_q;

endmodule

>>> rtl/tics_chk.sv
// Port-level checker for the tabulated inverse-CDF sampler, with its bind.
module tics_chk
  import tics_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic cmd_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic in_range_o
);

  // a stalled result transaction stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(in_range_o))
    else $error("in_range changed while stalled");

  // a sample occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_SAMPLE |=> in_stall_o)
    else $error("sample accepted without going busy");

  // a load leaves the block ready to accept input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_LOAD |=> !in_stall_o)
    else $error("load left the block busy");

  // results only come out of a sample in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result with no sample in flight");

endmodule

bind tabulated_inverse_cdf_sampler_top tics_chk u_tics_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .in_range_o  (in_range_o)
);
